// File: design/bba_pkg.sv
// Package: constants, payload structs and codes for the bitmap block allocator.
`default_nettype none
package bba_pkg;

	localparam int NBITS   = 8192;
	localparam int WORD_W  = 64;
	localparam int NWORDS  = NBITS / WORD_W;
	localparam int ADDR_W  = $clog2(NWORDS);
	localparam int OFF_W   = $clog2(WORD_W);
	localparam int IDX_W   = 13;
	localparam int CNT_W   = 14;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} seq_state_t;

	typedef struct packed {
		func_t              func;
		logic [IDX_W-1:0]   index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]   result_index;
		status_t            status;
		logic [CNT_W-1:0]   free_left;
	} rsp_t;

	typedef struct packed {
		logic   rd_en;
		addr_t  rd_addr;
		logic   wr_en;
		addr_t  wr_addr;
		word_t  wr_data;
	} map_req_t;

endpackage
`default_nettype wire

// File: design/bba_map.sv
// Bitmap storage: word memory with per-word valid bits, registered read.
`default_nettype none
module bba_map (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bba_pkg::map_req_t mreq,
	output      bba_pkg::word_t    rdata
);

	bba_pkg::word_t               mem [bba_pkg::NWORDS];
	logic [bba_pkg::NWORDS-1:0]   vld_q;
	bba_pkg::word_t               rdata_q;
	logic                         rvld_q;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rdata_q <= mem[mreq.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mreq.wr_en) begin
				vld_q[mreq.wr_addr] <= 1'b1;
			end
			if (mreq.rd_en) begin
				rvld_q <= vld_q[mreq.rd_addr];
			end
		end
	end

	// never-written words read as all free
	assign rdata = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// File: design/bba_seq.sv
// Request sequencer: word scan, read-modify-write of the bitmap, free count, result register.
`default_nettype none
module bba_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire bba_pkg::req_t     req,
	output      logic              busy,
	output      logic              done,
	output      bba_pkg::rsp_t     result,
	output      bba_pkg::map_req_t mreq,
	input  wire bba_pkg::word_t    rdata
);

	localparam bba_pkg::addr_t LAST_WORD = bba_pkg::ADDR_W'(bba_pkg::NWORDS - 1);
	localparam logic [bba_pkg::CNT_W-1:0] CNT_MAX = bba_pkg::CNT_W'(bba_pkg::NBITS);

	bba_pkg::seq_state_t          state_q, state_d;
	bba_pkg::func_t               func_q;
	bba_pkg::addr_t               word_q, word_d;
	logic [bba_pkg::OFF_W-1:0]    off_q, off_d;
	logic                         wrapped_q, wrapped_d;
	logic [bba_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic                         done_q, done_d;
	bba_pkg::rsp_t                rsp_q, rsp_d;

	bba_pkg::word_t               masked, free_bits, bit_sel;
	logic                         found;
	logic [bba_pkg::OFF_W-1:0]    pos;
	logic                         accept;

	assign accept = start && (state_q == bba_pkg::S_IDLE);

	// bits below the start offset count as used
	always_comb begin
		masked    = rdata | ((bba_pkg::WORD_W'(1) << off_q) - bba_pkg::WORD_W'(1));
		free_bits = ~masked;
		found     = |free_bits;
		pos       = '0;
		for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				pos = bba_pkg::OFF_W'(i);
			end
		end
	end

	assign bit_sel = bba_pkg::WORD_W'(1) << ((func_q == bba_pkg::FUNC_FREE) ? off_q : pos);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bba_pkg::S_IDLE: begin
				if (start) begin
					state_d = bba_pkg::S_EVAL;
				end
			end
			bba_pkg::S_EVAL: begin
				if (func_q == bba_pkg::FUNC_FREE || found ||
				    (word_q == LAST_WORD && wrapped_q)) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			default: state_d = bba_pkg::S_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		word_d       = word_q;
		off_d        = off_q;
		wrapped_d    = wrapped_q;
		cnt_d        = cnt_q;
		done_d       = 1'b0;
		rsp_d        = rsp_q;
		mreq         = '0;
		mreq.wr_addr = word_q;
		case (state_q)
			bba_pkg::S_IDLE: begin
				if (accept) begin
					word_d       = req.index[bba_pkg::IDX_W-1:bba_pkg::OFF_W];
					off_d        = (req.index == '0) ? bba_pkg::OFF_W'(1)
					                                 : req.index[bba_pkg::OFF_W-1:0];
					wrapped_d    = 1'b0;
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = req.index[bba_pkg::IDX_W-1:bba_pkg::OFF_W];
				end
			end
			bba_pkg::S_EVAL: begin
				if (func_q == bba_pkg::FUNC_FREE) begin
					done_d             = 1'b1;
					rsp_d.result_index = '0;
					if (rdata[off_q]) begin
						mreq.wr_en   = 1'b1;
						mreq.wr_data = rdata & ~bit_sel;
						if (cnt_q < CNT_MAX) begin
							cnt_d = cnt_q + 1'b1;
						end
						rsp_d.status = bba_pkg::ST_OK;
					end else begin
						rsp_d.status = bba_pkg::ST_BAD_FREE;
					end
					rsp_d.free_left = cnt_d;
				end else if (found) begin
					done_d       = 1'b1;
					mreq.wr_en   = 1'b1;
					mreq.wr_data = rdata | bit_sel;
					if (cnt_q != '0) begin
						cnt_d = cnt_q - 1'b1;
					end
					rsp_d.result_index = {word_q, pos};
					rsp_d.status       = bba_pkg::ST_OK;
					rsp_d.free_left    = cnt_d;
				end else if (word_q == LAST_WORD) begin
					if (wrapped_q) begin
						done_d             = 1'b1;
						rsp_d.result_index = '0;
						rsp_d.status       = bba_pkg::ST_FULL;
						rsp_d.free_left    = cnt_q;
					end else begin
						word_d       = '0;
						off_d        = bba_pkg::OFF_W'(1);
						wrapped_d    = 1'b1;
						mreq.rd_en   = 1'b1;
						mreq.rd_addr = '0;
					end
				end else begin
					word_d       = word_q + 1'b1;
					off_d        = '0;
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = word_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
			cnt_q   <= CNT_MAX;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
		end
		word_q    <= word_d;
		off_q     <= off_d;
		wrapped_q <= wrapped_d;
		rsp_q     <= rsp_d;
	end

	assign busy   = (state_q != bba_pkg::S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule
`default_nettype wire

// File: design/bitmap_block_allocator_goal.sv
// Top level of the goal-directed bitmap block allocator.
// A request is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off. A free reads
// only the word that holds its index. An allocate reads 64-bit bitmap words, one
// word per cycle from the single-port read of the bitmap memory, starting at the
// goal's word and wrapping once to index 1. A new request may be given in the cycle
// done is high. The bitmap needs no clearing pass after reset: per-word valid bits
// make unwritten words read as free.
`default_nettype none
module bitmap_block_allocator_goal (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire bba_pkg::req_t  req,
	output      logic           busy,
	output      logic           done,
	output      bba_pkg::rsp_t  result
);

	bba_pkg::map_req_t mreq;
	bba_pkg::word_t    rdata;

	bba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result),
		.mreq   (mreq),
		.rdata  (rdata)
	);

	bba_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.rdata  (rdata)
	);

endmodule
`default_nettype wire

// File: design/bba_chk.sv
// Port-level checker for the bitmap block allocator, bound to the top level.
`default_nettype none
module bba_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire bba_pkg::rsp_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != bba_pkg::ST_OK |-> result.result_index == '0)
		else $error("failed request returned an index");

	a_count_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.free_left <= bba_pkg::CNT_W'(bba_pkg::NBITS))
		else $error("free count out of range");

endmodule

bind bitmap_block_allocator_goal bba_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

// File: sim/tb_bitmap_block_allocator_goal.sv
// Self-checking testbench for the goal-directed bitmap block allocator.
`default_nettype none
module tb_bitmap_block_allocator_goal;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	bba_pkg::req_t req = '0;
	logic busy;
	logic done;
	bba_pkg::rsp_t result;

	bitmap_block_allocator_goal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// allocator state as predicted
	bit block_used [0:bba_pkg::NBITS-1];
	int blocks_free = bba_pkg::NBITS;

	bba_pkg::rsp_t pending_rsp [$];
	int live_blocks [$];
	bit idle_en = 1'b1;
	int errors = 0;
	int n_alloc = 0, n_full = 0, n_free = 0, n_bad_free = 0;
	int stall_cnt = 0;

	function automatic int find_clear(input int from);
		for (int i = from; i < bba_pkg::NBITS; i++)
			if (!block_used[i])
				return i;
		return 0;
	endfunction

	function automatic bba_pkg::rsp_t predict_rsp(input bba_pkg::req_t r);
		bba_pkg::rsp_t o;
		int pos;
		o = '0;
		o.status = bba_pkg::ST_OK;
		if (r.func == bba_pkg::FUNC_ALLOC) begin
			pos = find_clear((r.index == 0) ? 1 : int'(r.index));
			if (pos == 0)
				pos = find_clear(1);
			if (pos != 0) begin
				block_used[pos] = 1'b1;
				if (blocks_free > 0)
					blocks_free--;
				o.result_index = pos[bba_pkg::IDX_W-1:0];
			end else begin
				o.status = bba_pkg::ST_FULL;
			end
		end else begin
			if (int'(r.index) < bba_pkg::NBITS && block_used[r.index]) begin
				block_used[r.index] = 1'b0;
				if (blocks_free < bba_pkg::NBITS)
					blocks_free++;
			end else begin
				o.status = bba_pkg::ST_BAD_FREE;
			end
		end
		o.free_left = blocks_free[bba_pkg::CNT_W-1:0];
		return o;
	endfunction

	task automatic issue(input bba_pkg::func_t f, input logic [bba_pkg::IDX_W-1:0] idx);
		bba_pkg::req_t r;
		bba_pkg::rsp_t e;
		int k;
		r.func = f;
		r.index = idx;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		e = predict_rsp(r);
		pending_rsp.push_back(e);
		if (f == bba_pkg::FUNC_ALLOC) begin
			if (e.status == bba_pkg::ST_OK) begin
				n_alloc++;
				live_blocks.push_back(int'(e.result_index));
			end else begin
				n_full++;
			end
		end else if (e.status == bba_pkg::ST_OK) begin
			n_free++;
			k = -1;
			foreach (live_blocks[j])
				if (k < 0 && live_blocks[j] == int'(idx))
					k = j;
			if (k >= 0)
				live_blocks.delete(k);
		end else begin
			n_bad_free++;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic rand_request();
		int sel;
		int k;
		logic [bba_pkg::IDX_W-1:0] idx;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			idx = ($urandom_range(0, 9) == 0) ? '0
				: bba_pkg::IDX_W'($urandom_range(1, bba_pkg::NBITS - 1));
			issue(bba_pkg::FUNC_ALLOC, idx);
		end else if (sel < 90 && live_blocks.size() > 0) begin
			k = $urandom_range(0, live_blocks.size() - 1);
			issue(bba_pkg::FUNC_FREE, bba_pkg::IDX_W'(live_blocks[k]));
		end else begin
			idx = bba_pkg::IDX_W'($urandom_range(0, bba_pkg::NBITS - 1));
			issue(bba_pkg::FUNC_FREE, idx);
		end
	endtask

	// result checker and stall watchdog
	always @(posedge clk) begin
		bba_pkg::rsp_t e;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: timeout, no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					errors++;
				end else begin
					e = pending_rsp.pop_front();
					if (result.result_index !== e.result_index) begin
						$display("%0t: result_index expected %0d actual %0d",
							$time, e.result_index, result.result_index);
						errors++;
					end
					if (result.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, e.status, result.status);
						errors++;
					end
					if (result.free_left !== e.free_left) begin
						$display("%0t: free_left expected %0d actual %0d",
							$time, e.free_left, result.free_left);
						errors++;
					end
				end
			end
		end
	end

	task automatic test_directed();
		issue(bba_pkg::FUNC_FREE, 13'd0);
		issue(bba_pkg::FUNC_FREE, 13'd8191);
		issue(bba_pkg::FUNC_FREE, 13'd4096);
		issue(bba_pkg::FUNC_ALLOC, 13'd0);
		issue(bba_pkg::FUNC_ALLOC, 13'd0);
		issue(bba_pkg::FUNC_ALLOC, 13'd8191);
		issue(bba_pkg::FUNC_ALLOC, 13'd8191);
		issue(bba_pkg::FUNC_ALLOC, 13'd63);
		issue(bba_pkg::FUNC_ALLOC, 13'd63);
		issue(bba_pkg::FUNC_ALLOC, 13'd64);
		issue(bba_pkg::FUNC_FREE, 13'd64);
		issue(bba_pkg::FUNC_FREE, 13'd64);
		issue(bba_pkg::FUNC_ALLOC, 13'd0);
		issue(bba_pkg::FUNC_FREE, 13'd1);
		issue(bba_pkg::FUNC_ALLOC, 13'd0);
		issue(bba_pkg::FUNC_ALLOC, 13'd5461);
		issue(bba_pkg::FUNC_ALLOC, 13'd2730);
		issue(bba_pkg::FUNC_FREE, 13'd8191);
		issue(bba_pkg::FUNC_ALLOC, 13'd8190);
		issue(bba_pkg::FUNC_ALLOC, 13'd8190);
		issue(bba_pkg::FUNC_ALLOC, 13'd8190);
	endtask

	// fill the top word, force wrapped scans from goals in it, then release it
	task automatic test_wrap();
		for (int i = bba_pkg::NBITS - 64; i < bba_pkg::NBITS; i++)
			issue(bba_pkg::FUNC_ALLOC, bba_pkg::IDX_W'(i));
		issue(bba_pkg::FUNC_ALLOC, 13'd8191);
		issue(bba_pkg::FUNC_ALLOC, 13'd8160);
		issue(bba_pkg::FUNC_ALLOC, 13'd8128);
		drain();
		for (int i = bba_pkg::NBITS - 64; i < bba_pkg::NBITS; i++)
			issue(bba_pkg::FUNC_FREE, bba_pkg::IDX_W'(i));
	endtask

	task automatic test_random(input int n);
		repeat (n)
			rand_request();
	endtask

	task automatic test_back_to_back(input int n);
		idle_en = 1'b0;
		repeat (n)
			rand_request();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wrap();
		test_random(550);
		test_back_to_back(100);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d allocations, %0d out-of-space, %0d frees, %0d bad frees,",
			n_alloc, n_full, n_free, n_bad_free);
		$display("including a full top word, wrapped scans and random traffic; %0d errors",
			errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: bitmap_block_allocator_goal.f
design/bba_pkg.sv
design/bba_map.sv
design/bba_seq.sv
design/bitmap_block_allocator_goal.sv
design/bba_chk.sv
sim/tb_bitmap_block_allocator_goal.sv
